// ===== hw/rtl/light_source_intensity_eval_assert.svh =====
// Assertion macros for the light source evaluation block.
`ifndef LIGHT_SOURCE_INTENSITY_EVAL_ASSERT_SVH
`define LIGHT_SOURCE_INTENSITY_EVAL_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LSIE_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Condition must never be seen.
`define LSIE_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

// ===== hw/rtl/lsie_pkg.sv =====
`default_nettype none
package lsie_pkg;

    localparam int COORD_WIDTH = 32;
    localparam int MAG_W       = COORD_WIDTH + 1;
    localparam int NORM_W      = 30;
    localparam int SQ_W        = 2 * NORM_W;
    localparam int SUM_W       = SQ_W + 2;
    localparam int LEN_W       = NORM_W + 1;
    localparam int SQRT_STEPS  = SUM_W / 2;
    localparam int FRAC14      = 14;
    localparam int ONE14       = 16384;
    localparam int DIV_BITS    = 15;
    localparam int IN_DATA_W   = ((3 * COORD_WIDTH + 7) / 8) * 8;
    localparam int OUT_DATA_W  = 64;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = (COORD_WIDTH > 16) ? COORD_WIDTH : 16;

    // raised-cosine polynomial, Q30
    localparam logic [30:0] Q30 = 31'd1073741824;
    localparam logic [30:0] CF1 = 31'd1324675879;
    localparam logic [28:0] CF2 = 29'd272375560;
    localparam logic [24:0] CF3 = 25'd22401992;
    localparam logic [19:0] CF4 = 20'd987048;

    localparam logic [CFG_IDX_W-1:0] REG_LIGHT_KIND  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LIGHT_X     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LIGHT_Y     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LIGHT_Z     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SPOT_AXIS_X = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SPOT_AXIS_Y = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SPOT_AXIS_Z = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_CONE_COSINE = 3'd7;

    typedef enum logic [1:0]
    {
        KIND_DIR   = 2'd0,
        KIND_POINT = 2'd1,
        KIND_SOFT  = 2'd2,
        KIND_SHARP = 2'd3
    } kind_t;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef logic signed [15:0]            q14_t;
    typedef logic [14:0]                   inten_t;
    typedef logic [2:0][15:0]              vec_t;

    typedef struct packed
    {
        logic [2:0]              neg;
        logic                    zero;
        logic [2:0][NORM_W-1:0]  m;
    } norm_t;

    typedef struct packed
    {
        norm_t             nrm;
        logic [SUM_W-1:0]  sum;
    } front_t;

    typedef struct packed
    {
        norm_t             nrm;
        logic [LEN_W-1:0]  len;
    } root_t;

endpackage
`default_nettype wire

// ===== hw/rtl/light_source_intensity_eval.sv =====
// Light source evaluation. Each transaction in carries one surface point
// (x, y, z, Q16.16); each transaction out carries the unit vector from the
// point toward the light (Q2.14) and the intensity falling there (unsigned
// Q1.14, 16384 is full). The light is set up through the register write
// port, which must only be used while no transaction is in flight. The
// block is a fixed pipeline of 78 stages: one point enters per clock while
// the pipeline is not held. Most of the depth comes from the bit-per-stage
// square root (31 stages) and the two restoring dividers (15 stages each),
// plus the normalise front end and the falloff polynomial. When the output
// is not taken the whole pipeline holds and input ready drops.
`default_nettype none
module light_source_intensity_eval
(
    input  logic                                clk,
    input  logic                                rst_n,
    // slave: point_x, point_y, point_z from bit 0 up
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [lsie_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // master: to_light_x, to_light_y, to_light_z, intensity, pad bit
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [lsie_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    // register write port
    input  logic                                cfg_we,
    input  logic [lsie_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [lsie_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import lsie_pkg::*;

    `include "light_source_intensity_eval_assert.svh"

    localparam logic signed [COORD_WIDTH:0] DIR_MAX = ONE14;
    localparam logic signed [COORD_WIDTH:0] DIR_MIN = -ONE14;

    kind_t  kind_reg;
    coord_t light_x_reg, light_y_reg, light_z_reg;
    q14_t   axis_x_reg, axis_y_reg, axis_z_reg, cone_reg;

    logic   adv;
    logic   front_vld, root_vld, vdiv_vld, spot_vld;
    front_t front_data;
    root_t  root_data;
    vec_t   vdiv_vec, dir_vec, out_vec;
    inten_t out_intensity;
    coord_t lreg [3];

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg    <= KIND_DIR;
            light_x_reg <= '0;
            light_y_reg <= '0;
            light_z_reg <= COORD_WIDTH'(65536);
            axis_x_reg  <= '0;
            axis_y_reg  <= '0;
            axis_z_reg  <= 16'(ONE14);
            cone_reg    <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_LIGHT_KIND:  kind_reg    <= kind_t'(cfg_data[1:0]);
                REG_LIGHT_X:     light_x_reg <= cfg_data[COORD_WIDTH-1:0];
                REG_LIGHT_Y:     light_y_reg <= cfg_data[COORD_WIDTH-1:0];
                REG_LIGHT_Z:     light_z_reg <= cfg_data[COORD_WIDTH-1:0];
                REG_SPOT_AXIS_X: axis_x_reg  <= cfg_data[15:0];
                REG_SPOT_AXIS_Y: axis_y_reg  <= cfg_data[15:0];
                REG_SPOT_AXIS_Z: axis_z_reg  <= cfg_data[15:0];
                REG_CONE_COSINE: cone_reg    <= cfg_data[15:0];
                default:         kind_reg    <= kind_reg;
            endcase
        end
    end

    // directional light: stored direction rounded to Q2.14, half up, clamped
    assign lreg[0] = light_x_reg;
    assign lreg[1] = light_y_reg;
    assign lreg[2] = light_z_reg;

    always_comb
    begin
        logic signed [COORD_WIDTH:0] s;
        for (int i = 0; i < 3; i++)
        begin
            s = (COORD_WIDTH + 1)'(lreg[i]) + (COORD_WIDTH + 1)'(2);
            s = s >>> 2;
            if (s > DIR_MAX)
                dir_vec[i] = 16'(ONE14);
            else if (s < DIR_MIN)
                dir_vec[i] = -16'(ONE14);
            else
                dir_vec[i] = s[15:0];
        end
    end

    // whole pipeline advances unless a result is waiting
    assign adv           = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = adv;

    lsie_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (adv),
        .in_valid   (s_axis_tvalid),
        .point_x    (s_axis_tdata[COORD_WIDTH-1:0]),
        .point_y    (s_axis_tdata[2*COORD_WIDTH-1:COORD_WIDTH]),
        .point_z    (s_axis_tdata[3*COORD_WIDTH-1:2*COORD_WIDTH]),
        .light_x    (light_x_reg),
        .light_y    (light_y_reg),
        .light_z    (light_z_reg),
        .light_kind (kind_reg),
        .out_valid  (front_vld),
        .out_data   (front_data)
    );

    lsie_isqrt u_isqrt
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (front_vld),
        .in_data   (front_data),
        .out_valid (root_vld),
        .out_data  (root_data)
    );

    lsie_vdiv u_vdiv
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (root_vld),
        .in_data   (root_data),
        .out_valid (vdiv_vld),
        .out_vec   (vdiv_vec)
    );

    lsie_spot u_spot
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .en            (adv),
        .in_valid      (vdiv_vld),
        .in_vec        (vdiv_vec),
        .dir_vec       (dir_vec),
        .light_kind    (kind_reg),
        .spot_axis_x   (axis_x_reg),
        .spot_axis_y   (axis_y_reg),
        .spot_axis_z   (axis_z_reg),
        .cone_cosine   (cone_reg),
        .out_valid     (spot_vld),
        .out_vec       (out_vec),
        .out_intensity (out_intensity)
    );

    assign m_axis_tvalid = spot_vld;
    assign m_axis_tdata  = {1'b0, out_intensity, out_vec[2], out_vec[1], out_vec[0]};

    `LSIE_ASSERT_IMP(a_plain_full, clk, rst_n,
        m_axis_tvalid && (kind_reg == KIND_DIR || kind_reg == KIND_POINT),
        out_intensity == 15'(ONE14), "non-spot light must give full intensity")
    `LSIE_ASSERT_IMP(a_sharp_binary, clk, rst_n,
        m_axis_tvalid && kind_reg == KIND_SHARP,
        out_intensity == '0 || out_intensity == 15'(ONE14), "sharp spot gave partial light")
    `LSIE_ASSERT_NEVER(a_inten_range, clk, rst_n,
        m_axis_tvalid && out_intensity > 15'(ONE14), "intensity above one")
    `LSIE_ASSERT_NEVER(a_stall_blocks_input, clk, rst_n,
        m_axis_tvalid && !m_axis_tready && s_axis_tready, "input taken while output stalled")

endmodule
`default_nettype wire

// ===== hw/rtl/lsie_front.sv =====
`default_nettype none
module lsie_front
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_valid,
    input  lsie_pkg::coord_t point_x,
    input  lsie_pkg::coord_t point_y,
    input  lsie_pkg::coord_t point_z,
    input  lsie_pkg::coord_t light_x,
    input  lsie_pkg::coord_t light_y,
    input  lsie_pkg::coord_t light_z,
    input  lsie_pkg::kind_t  light_kind,
    output logic             out_valid,
    output lsie_pkg::front_t out_data
);
    import lsie_pkg::*;

    localparam int POS_W = $clog2(MAG_W);
    localparam int SH_W  = (MAG_W > NORM_W) ? MAG_W : NORM_W;

    logic [4:0] vld_reg;

    coord_t lt [3];
    coord_t pt [3];
    logic signed [MAG_W-1:0] diff [3];

    logic [2:0]             neg1_next, neg1_reg;
    logic [MAG_W-1:0]       mag1_next [3];
    logic [MAG_W-1:0]       mag1_reg [3];

    logic [MAG_W-1:0]       orv;
    logic [POS_W-1:0]       pos2_next, pos2_reg;
    logic [MAG_W-1:0]       mag2_reg [3];
    logic [2:0]             neg2_reg;
    logic                   zero2_reg;

    norm_t                  nrm3_next, nrm3_reg;
    norm_t                  nrm4_reg, nrm5_reg;
    logic [SQ_W-1:0]        sq4_reg [3];
    logic [SUM_W-1:0]       sum5_reg;

    assign lt[0] = light_x;
    assign lt[1] = light_y;
    assign lt[2] = light_z;
    assign pt[0] = point_x;
    assign pt[1] = point_y;
    assign pt[2] = point_z;

    // point light looks from the point to the light, spots the other way
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (light_kind == KIND_POINT)
                diff[i] = MAG_W'(lt[i]) - MAG_W'(pt[i]);
            else
                diff[i] = MAG_W'(pt[i]) - MAG_W'(lt[i]);
            neg1_next[i] = diff[i][MAG_W-1];
            mag1_next[i] = diff[i][MAG_W-1] ? MAG_W'(-diff[i]) : MAG_W'(diff[i]);
        end
    end

    // leading one of the largest magnitude
    always_comb
    begin
        orv       = mag1_reg[0] | mag1_reg[1] | mag1_reg[2];
        pos2_next = '0;
        for (int i = 0; i < MAG_W; i++)
        begin
            if (orv[i])
                pos2_next = POS_W'(i);
        end
    end

    // common shift puts the top bit at NORM_W-1
    always_comb
    begin
        nrm3_next.neg  = neg2_reg;
        nrm3_next.zero = zero2_reg;
        for (int i = 0; i < 3; i++)
        begin
            if (int'(pos2_reg) >= NORM_W - 1)
                nrm3_next.m[i] = NORM_W'(SH_W'(mag2_reg[i]) >> (int'(pos2_reg) - (NORM_W - 1)));
            else
                nrm3_next.m[i] = NORM_W'(SH_W'(mag2_reg[i]) << ((NORM_W - 1) - int'(pos2_reg)));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[3:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            neg1_reg  <= neg1_next;
            mag1_reg  <= mag1_next;
            mag2_reg  <= mag1_reg;
            neg2_reg  <= neg1_reg;
            pos2_reg  <= pos2_next;
            zero2_reg <= (orv == '0);
            nrm3_reg  <= nrm3_next;
            nrm4_reg  <= nrm3_reg;
            for (int i = 0; i < 3; i++)
                sq4_reg[i] <= SQ_W'(nrm3_reg.m[i]) * SQ_W'(nrm3_reg.m[i]);
            nrm5_reg  <= nrm4_reg;
            sum5_reg  <= SUM_W'(sq4_reg[0]) + SUM_W'(sq4_reg[1]) + SUM_W'(sq4_reg[2]);
        end
    end

    assign out_valid    = vld_reg[4];
    assign out_data.nrm = nrm5_reg;
    assign out_data.sum = sum5_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/lsie_isqrt.sv =====
`default_nettype none
module lsie_isqrt
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_valid,
    input  lsie_pkg::front_t in_data,
    output logic             out_valid,
    output lsie_pkg::root_t  out_data
);
    import lsie_pkg::*;

    logic [SQRT_STEPS-1:0] vld_reg;
    logic [SUM_W-1:0]      n_reg [SQRT_STEPS];
    logic [SUM_W-1:0]      r_reg [SQRT_STEPS];
    norm_t                 nrm_reg [SQRT_STEPS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[SQRT_STEPS-2:0], in_valid};
    end

    // one result bit per stage, bit weight falls by four each step
    for (genvar k = 0; k < SQRT_STEPS; k++)
    begin : g_step
        logic [SUM_W-1:0] n_in, r_in, n_next, r_next, bitw;
        logic [SUM_W:0]   trial;
        norm_t            nrm_in;

        if (k == 0)
        begin : g_first
            assign n_in   = in_data.sum;
            assign r_in   = '0;
            assign nrm_in = in_data.nrm;
        end
        else
        begin : g_rest
            assign n_in   = n_reg[k-1];
            assign r_in   = r_reg[k-1];
            assign nrm_in = nrm_reg[k-1];
        end

        assign bitw  = SUM_W'(1) << (2 * (SQRT_STEPS - 1 - k));
        assign trial = {1'b0, r_in} + {1'b0, bitw};

        always_comb
        begin
            if ({1'b0, n_in} >= trial)
            begin
                n_next = n_in - trial[SUM_W-1:0];
                r_next = (r_in >> 1) + bitw;
            end
            else
            begin
                n_next = n_in;
                r_next = r_in >> 1;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                n_reg[k]   <= n_next;
                r_reg[k]   <= r_next;
                nrm_reg[k] <= nrm_in;
            end
        end
    end

    assign out_valid    = vld_reg[SQRT_STEPS-1];
    assign out_data.nrm = nrm_reg[SQRT_STEPS-1];
    assign out_data.len = r_reg[SQRT_STEPS-1][LEN_W-1:0];

endmodule
`default_nettype wire

// ===== hw/rtl/lsie_vdiv.sv =====
`default_nettype none
module lsie_vdiv
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            in_valid,
    input  lsie_pkg::root_t in_data,
    output logic            out_valid,
    output lsie_pkg::vec_t  out_vec
);
    import lsie_pkg::*;

    localparam int DREM_W = LEN_W + DIV_BITS;

    logic [DIV_BITS:0]      vld_reg;
    logic [DREM_W-1:0]      rem_reg [DIV_BITS][3];
    logic [DIV_BITS-1:0]    q_reg [DIV_BITS][3];
    logic [LEN_W-1:0]       len_reg [DIV_BITS];
    logic [2:0]             neg_reg [DIV_BITS];
    logic                   zero_reg [DIV_BITS];
    vec_t                   vec_next, vec_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[DIV_BITS-1:0], in_valid};
    end

    // restoring division, three lanes share the divisor
    for (genvar k = 0; k < DIV_BITS; k++)
    begin : g_step
        localparam int J = DIV_BITS - 1 - k;
        logic [DREM_W-1:0]   rem_in [3];
        logic [DREM_W-1:0]   rem_next [3];
        logic [DIV_BITS-1:0] q_in [3];
        logic [DIV_BITS-1:0] q_next [3];
        logic [LEN_W-1:0]    len_in;
        logic [2:0]          neg_in;
        logic                zero_in;
        logic [DREM_W-1:0]   cmp;

        if (k == 0)
        begin : g_first
            for (genvar i = 0; i < 3; i++)
            begin : g_lane
                assign rem_in[i] = (DREM_W'(in_data.nrm.m[i]) << FRAC14)
                                 + DREM_W'(in_data.len >> 1);
                assign q_in[i]   = '0;
            end
            assign len_in  = in_data.len;
            assign neg_in  = in_data.nrm.neg;
            assign zero_in = in_data.nrm.zero;
        end
        else
        begin : g_rest
            for (genvar i = 0; i < 3; i++)
            begin : g_lane
                assign rem_in[i] = rem_reg[k-1][i];
                assign q_in[i]   = q_reg[k-1][i];
            end
            assign len_in  = len_reg[k-1];
            assign neg_in  = neg_reg[k-1];
            assign zero_in = zero_reg[k-1];
        end

        assign cmp = DREM_W'(len_in) << J;

        always_comb
        begin
            for (int i = 0; i < 3; i++)
            begin
                if (rem_in[i] >= cmp)
                begin
                    rem_next[i] = rem_in[i] - cmp;
                    q_next[i]   = q_in[i] | (DIV_BITS'(1) << J);
                end
                else
                begin
                    rem_next[i] = rem_in[i];
                    q_next[i]   = q_in[i];
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    rem_reg[k][i] <= rem_next[i];
                    q_reg[k][i]   <= q_next[i];
                end
                len_reg[k]  <= len_in;
                neg_reg[k]  <= neg_in;
                zero_reg[k] <= zero_in;
            end
        end
    end

    // clamp to one, apply sign; zero-length vector gives zero
    always_comb
    begin
        logic [DIV_BITS-1:0] c;
        for (int i = 0; i < 3; i++)
        begin
            c = (q_reg[DIV_BITS-1][i] > DIV_BITS'(ONE14)) ? DIV_BITS'(ONE14)
                                                          : q_reg[DIV_BITS-1][i];
            if (zero_reg[DIV_BITS-1])
                vec_next[i] = '0;
            else if (neg_reg[DIV_BITS-1][i])
                vec_next[i] = -16'(c);
            else
                vec_next[i] = 16'(c);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
            vec_reg <= vec_next;
    end

    assign out_valid = vld_reg[DIV_BITS];
    assign out_vec   = vec_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/lsie_spot.sv =====
`default_nettype none
module lsie_spot
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            in_valid,
    input  lsie_pkg::vec_t  in_vec,
    input  lsie_pkg::vec_t  dir_vec,
    input  lsie_pkg::kind_t light_kind,
    input  lsie_pkg::q14_t  spot_axis_x,
    input  lsie_pkg::q14_t  spot_axis_y,
    input  lsie_pkg::q14_t  spot_axis_z,
    input  lsie_pkg::q14_t  cone_cosine,
    output logic            out_valid,
    output lsie_pkg::vec_t  out_vec,
    output lsie_pkg::inten_t out_intensity
);
    import lsie_pkg::*;

    localparam int ST_DOT  = 1;
    localparam int ST_DIV0 = 3;
    localparam int ST_P1   = ST_DIV0 + DIV_BITS;
    localparam int ST_OUT  = ST_P1 + 7;
    localparam int NSTG    = ST_OUT + 1;

    typedef enum logic [1:0]
    {
        INT_ZERO,
        INT_FULL,
        INT_CALC
    } imode_t;

    typedef struct packed
    {
        imode_t mode;
        vec_t   tl;
    } sside_t;

    logic [NSTG-1:0]       vld_reg;
    sside_t                side_reg [ST_DOT:ST_OUT];
    sside_t                side_next;

    q14_t                  ax [3];
    logic signed [31:0]    prod_reg [3];
    vec_t                  vec1_reg;

    logic signed [33:0]    dot;
    logic signed [33:0]    dsum;
    logic signed [19:0]    dr, dc, cone20;
    logic signed [17:0]    den_full;
    logic [14:0]           dc_reg;
    logic [15:0]           den_reg;

    logic [14:0]           dnum;
    logic [28:0]           num_next, num_reg;
    logic                  ovf_next, ovf_reg;
    logic [15:0]           den3_reg;

    logic [28:0]           drem_reg [DIV_BITS];
    logic [DIV_BITS-1:0]   dq_reg [DIV_BITS];
    logic [15:0]           dden_reg [DIV_BITS];
    logic                  dovf_reg [DIV_BITS];

    logic [14:0]           tsel;
    logic [29:0]           tsq;
    logic [30:0]           x2_p1_reg, x2_p2_reg, x2_p3_reg, x2_p4_reg;
    logic [50:0]           a_reg;
    logic [24:0]           h3;
    logic [55:0]           b_reg;
    logic [28:0]           h2;
    logic [59:0]           c_reg;
    logic [30:0]           h1;
    logic [61:0]           d_reg;
    logic [31:0]           p;
    logic [30:0]           g_next, g_reg;
    logic [61:0]           gg_reg;
    logic [62:0]           rnd;
    logic [16:0]           rsh;
    inten_t                inten_next, inten_reg;

    assign ax[0] = spot_axis_x;
    assign ax[1] = spot_axis_y;
    assign ax[2] = spot_axis_z;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[NSTG-2:0], in_valid};
    end

    // dot product rounded to Q2.14, cone tests, output direction
    always_comb
    begin
        dot    = 34'(prod_reg[0]) + 34'(prod_reg[1]) + 34'(prod_reg[2]);
        dsum   = dot + 34'sd8192;
        dr     = 20'(dsum >>> FRAC14);
        dc     = (dr > 20'sd16384) ? 20'sd16384 : dr;
        cone20 = 20'(cone_cosine);
        case (light_kind)
            KIND_SHARP:
                side_next.mode = (dr < cone20) ? INT_ZERO : INT_FULL;
            KIND_SOFT:
            begin
                if (dc <= 20'sd0 || dc < cone20)
                    side_next.mode = INT_ZERO;
                else if (cone20 == 20'sd16384)
                    side_next.mode = INT_FULL;
                else
                    side_next.mode = INT_CALC;
            end
            default:
                side_next.mode = INT_FULL;
        endcase
        for (int i = 0; i < 3; i++)
        begin
            case (light_kind)
                KIND_DIR:   side_next.tl[i] = dir_vec[i];
                KIND_POINT: side_next.tl[i] = vec1_reg[i];
                default:    side_next.tl[i] = -vec1_reg[i];
            endcase
        end
        den_full = 18'sd16384 - 18'(cone_cosine);
    end

    // falloff numerator with half-divisor rounding; overflow means t clamps
    always_comb
    begin
        dnum     = 15'(ONE14) - dc_reg;
        num_next = (29'(dnum) << FRAC14) + 29'(den_reg >> 1);
        ovf_next = {3'b000, num_next} >= (32'(den_reg) << DIV_BITS);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
                prod_reg[i] <= $signed(in_vec[i]) * ax[i];
            vec1_reg  <= in_vec;
            dc_reg    <= dc[14:0];
            den_reg   <= den_full[15:0];
            num_reg   <= num_next;
            ovf_reg   <= ovf_next;
            den3_reg  <= den_reg;
        end
    end

    for (genvar k = 0; k < DIV_BITS; k++)
    begin : g_div
        localparam int J = DIV_BITS - 1 - k;
        logic [28:0]         rem_in, rem_next;
        logic [DIV_BITS-1:0] q_in, q_next;
        logic [15:0]         den_in;
        logic                ovf_in;
        logic [30:0]         cmp;

        if (k == 0)
        begin : g_first
            assign rem_in = num_reg;
            assign q_in   = '0;
            assign den_in = den3_reg;
            assign ovf_in = ovf_reg;
        end
        else
        begin : g_rest
            assign rem_in = drem_reg[k-1];
            assign q_in   = dq_reg[k-1];
            assign den_in = dden_reg[k-1];
            assign ovf_in = dovf_reg[k-1];
        end

        assign cmp = 31'(den_in) << J;

        always_comb
        begin
            if (31'(rem_in) >= cmp)
            begin
                rem_next = rem_in - cmp[28:0];
                q_next   = q_in | (DIV_BITS'(1) << J);
            end
            else
            begin
                rem_next = rem_in;
                q_next   = q_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                drem_reg[k] <= rem_next;
                dq_reg[k]   <= q_next;
                dden_reg[k] <= den_in;
                dovf_reg[k] <= ovf_in;
            end
        end
    end

    // cosine polynomial in Horner form, at most one multiply per stage; then squared, rounded and clamped
    always_comb
    begin
        tsel = (dovf_reg[DIV_BITS-1] || dq_reg[DIV_BITS-1] > 15'(ONE14))
             ? 15'(ONE14) : dq_reg[DIV_BITS-1];
        tsq  = 30'(tsel) * 30'(tsel);
        h3   = CF3 - 25'(a_reg[50:30]);
        h2   = CF2 - 29'(b_reg[55:30]);
        h1   = CF1 - 31'(c_reg[59:30]);
        p    = d_reg[61:30];
        g_next = (p >= 32'(Q30)) ? 31'd0 : (Q30 - p[30:0]);
        rnd  = 63'(gg_reg) + (63'(1) << 45);
        rsh  = rnd[62:46];
        case (side_reg[ST_OUT-1].mode)
            INT_ZERO: inten_next = '0;
            INT_CALC: inten_next = (rsh > 17'(ONE14)) ? 15'(ONE14) : rsh[14:0];
            default:  inten_next = 15'(ONE14);
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x2_p1_reg <= 31'(tsq) << 2;
            a_reg     <= 51'(x2_p1_reg) * 51'(CF4);
            x2_p2_reg <= x2_p1_reg;
            b_reg     <= 56'(x2_p2_reg) * 56'(h3);
            x2_p3_reg <= x2_p2_reg;
            c_reg     <= 60'(x2_p3_reg) * 60'(h2);
            x2_p4_reg <= x2_p3_reg;
            d_reg     <= 62'(x2_p4_reg) * 62'(h1);
            g_reg     <= g_next;
            gg_reg    <= 62'(g_reg) * 62'(g_reg);
            inten_reg <= inten_next;
            side_reg[ST_DOT] <= side_next;
            for (int k = ST_DOT + 1; k <= ST_OUT; k++)
                side_reg[k] <= side_reg[k-1];
        end
    end

    assign out_valid     = vld_reg[NSTG-1];
    assign out_vec       = side_reg[ST_OUT].tl;
    assign out_intensity = inten_reg;

endmodule
`default_nettype wire

// ===== tb/sv/testbench.sv =====
`default_nettype none
module testbench;

    import lsie_pkg::*;

    // clock period and reset length
    localparam int HALF_PERIOD = 6;
    localparam int RESET_CYCLES = 8;
    // the pipeline is 78 deep; allow some margin on top
    localparam int PIPE_DEPTH = 78;
    localparam int SETTLE_CYCLES = PIPE_DEPTH + 20;
    localparam int IDLE_PERCENT = 11;

    typedef longint vec3_t[3];

    // one outgoing transaction, as predicted
    typedef struct
    {
        q14_t   dir_x;
        q14_t   dir_y;
        q14_t   dir_z;
        inten_t inten;
    } light_result_t;

    logic                   clk;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_DATA_W-1:0]   s_axis_tdata;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_DATA_W-1:0]  m_axis_tdata;
    logic                   cfg_we;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    // testbench copy of the light set-up
    kind_t   light_kind;
    coord_t  light_pos[3];
    q14_t    spot_axis[3];
    q14_t    cone_cos;

    light_result_t  expected_q[$];
    int             fail_count;
    bit             no_idling;

    light_source_intensity_eval i_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #HALF_PERIOD;
        clk = 1'b0;
        #HALF_PERIOD;
    end

    // ---------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------

    function automatic longint unsigned int_sqrt(input longint unsigned n);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n)
            b >>= 2;
        while (b != 0)
        begin
            if (n >= r + b)
            begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    // Scale so the largest magnitude sits in [2^29, 2^30), then divide by
    // the truncated length with half-up rounding.
    function automatic vec3_t normalise(input vec3_t d);
        longint unsigned mag[3];
        longint unsigned mx;
        longint unsigned sum;
        longint unsigned len;
        longint unsigned c;
        vec3_t o;
        mx = 0;
        for (int i = 0; i < 3; i++)
        begin
            mag[i] = (d[i] < 0) ? longint'(-d[i]) : longint'(d[i]);
            if (mag[i] > mx)
                mx = mag[i];
        end
        if (mx == 0)
        begin
            o = '{0, 0, 0};
            return o;
        end
        while (mx >= (64'd1 << 30))
        begin
            mx >>= 1;
            for (int i = 0; i < 3; i++)
                mag[i] >>= 1;
        end
        while (mx < (64'd1 << 29))
        begin
            mx <<= 1;
            for (int i = 0; i < 3; i++)
                mag[i] <<= 1;
        end
        sum = 0;
        for (int i = 0; i < 3; i++)
            sum += mag[i] * mag[i];
        len = int_sqrt(sum);
        for (int i = 0; i < 3; i++)
        begin
            c = (mag[i] * ONE14 + len / 2) / len;
            if (c > ONE14)
                c = ONE14;
            o[i] = (d[i] < 0) ? -longint'(c) : longint'(c);
        end
        return o;
    endfunction

    // raised-cosine falloff, squared cos(pi/2 * t) polynomial
    function automatic longint raised_cosine(input longint dot, input longint cone);
        longint unsigned den;
        longint unsigned t14;
        longint unsigned x2;
        longint unsigned h3;
        longint unsigned h2;
        longint unsigned h1;
        longint unsigned p;
        longint unsigned g;
        den = ONE14 - cone;
        t14 = ((ONE14 - dot) * ONE14 + den / 2) / den;
        if (t14 > ONE14)
            t14 = ONE14;
        x2 = (t14 * t14) << 2;
        h3 = 64'(CF3) - ((x2 * 64'(CF4)) >> 30);
        h2 = 64'(CF2) - ((x2 * h3) >> 30);
        h1 = 64'(CF1) - ((x2 * h2) >> 30);
        p = (x2 * h1) >> 30;
        g = (p >= 64'(Q30)) ? 0 : 64'(Q30) - p;
        g = (g * g + (64'd1 << 45)) >> 46;
        if (g > ONE14)
            g = ONE14;
        return longint'(g);
    endfunction

    function automatic light_result_t predict_lighting(input coord_t pt[3]);
        vec3_t d;
        vec3_t v;
        longint inten;
        longint dot;
        longint cone;
        light_result_t r;
        inten = ONE14;
        cone = longint'(cone_cos);
        case (light_kind)
            KIND_DIR:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    v[i] = (longint'(light_pos[i]) + 2) >>> 2;
                    if (v[i] > ONE14)
                        v[i] = ONE14;
                    if (v[i] < -ONE14)
                        v[i] = -ONE14;
                end
            end
            KIND_POINT:
            begin
                for (int i = 0; i < 3; i++)
                    d[i] = longint'(light_pos[i]) - longint'(pt[i]);
                v = normalise(d);
            end
            default:
            begin
                for (int i = 0; i < 3; i++)
                    d[i] = longint'(pt[i]) - longint'(light_pos[i]);
                v = normalise(d);
                dot = 0;
                for (int i = 0; i < 3; i++)
                    dot += v[i] * longint'(spot_axis[i]);
                dot = (dot + 8192) >>> 14;
                if (light_kind == KIND_SHARP)
                    inten = (dot < cone) ? 0 : ONE14;
                else
                begin
                    if (dot > ONE14)
                        dot = ONE14;
                    if (dot <= 0 || dot < cone)
                        inten = 0;
                    else if (cone == ONE14)
                        inten = ONE14;
                    else
                        inten = raised_cosine(dot, cone);
                end
                for (int i = 0; i < 3; i++)
                    v[i] = -v[i];
            end
        endcase
        r.dir_x = q14_t'(v[0]);
        r.dir_y = q14_t'(v[1]);
        r.dir_z = q14_t'(v[2]);
        r.inten = inten_t'(inten);
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Result side: random back-pressure and the checker
    // ---------------------------------------------------------------

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= no_idling || ($urandom_range(0, 99) >= IDLE_PERCENT);
    end

    always @(posedge clk)
    begin
        light_result_t exp_r;
        light_result_t got;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.dir_x = m_axis_tdata[15:0];
            got.dir_y = m_axis_tdata[31:16];
            got.dir_z = m_axis_tdata[47:32];
            got.inten = m_axis_tdata[62:48];
            if (expected_q.size() == 0)
            begin
                $display("%0t: unexpected transaction out, tdata %h", $time, m_axis_tdata);
                fail_count++;
            end
            else
            begin
                exp_r = expected_q.pop_front();
                if (got.dir_x !== exp_r.dir_x)
                begin
                    $display("%0t: to_light_x expected %0d actual %0d",
                             $time, exp_r.dir_x, got.dir_x);
                    fail_count++;
                end
                if (got.dir_y !== exp_r.dir_y)
                begin
                    $display("%0t: to_light_y expected %0d actual %0d",
                             $time, exp_r.dir_y, got.dir_y);
                    fail_count++;
                end
                if (got.dir_z !== exp_r.dir_z)
                begin
                    $display("%0t: to_light_z expected %0d actual %0d",
                             $time, exp_r.dir_z, got.dir_z);
                    fail_count++;
                end
                if (got.inten !== exp_r.inten)
                begin
                    $display("%0t: intensity expected %0d actual %0d",
                             $time, exp_r.inten, got.inten);
                    fail_count++;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------

    // Register write; only called with nothing in flight.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            REG_LIGHT_KIND:  light_kind = kind_t'(value[1:0]);
            REG_LIGHT_X:     light_pos[0] = value;
            REG_LIGHT_Y:     light_pos[1] = value;
            REG_LIGHT_Z:     light_pos[2] = value;
            REG_SPOT_AXIS_X: spot_axis[0] = value[15:0];
            REG_SPOT_AXIS_Y: spot_axis[1] = value[15:0];
            REG_SPOT_AXIS_Z: spot_axis[2] = value[15:0];
            REG_CONE_COSINE: cone_cos = value[15:0];
            default: ;
        endcase
    endtask

    task automatic set_light(input kind_t kind, input coord_t lx, input coord_t ly,
                             input coord_t lz);
        write_reg(REG_LIGHT_KIND, 32'(kind));
        write_reg(REG_LIGHT_X, lx);
        write_reg(REG_LIGHT_Y, ly);
        write_reg(REG_LIGHT_Z, lz);
    endtask

    task automatic set_spot(input q14_t axx, input q14_t axy, input q14_t axz,
                            input q14_t cone);
        write_reg(REG_SPOT_AXIS_X, 32'(axx));
        write_reg(REG_SPOT_AXIS_Y, 32'(axy));
        write_reg(REG_SPOT_AXIS_Z, 32'(axz));
        write_reg(REG_CONE_COSINE, 32'(cone));
    endtask

    // One transaction in. tvalid is left high; wait_idle lowers it, and
    // the next call lowers it only for a random idle gap.
    task automatic send_point(input coord_t px, input coord_t py, input coord_t pz);
        coord_t pt[3];
        pt = '{px, py, pz};
        if (!no_idling && $urandom_range(0, 99) < IDLE_PERCENT)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4))
                @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {pz, py, px};
        do
            @(posedge clk);
        while (!s_axis_tready);
        expected_q.push_back(predict_lighting(pt));
    endtask

    // Drain the pipeline before touching the registers.
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (4)
            @(posedge clk);
    endtask

    function automatic coord_t rand_coord();
        case ($urandom_range(0, 3))
            0:       return coord_t'($urandom);
            1:       return coord_t'($urandom_range(0, 65535)) - 32768;
            2:       return coord_t'(int'($urandom_range(0, 32'h00ffffff)) - 32'h00800000);
            default: return coord_t'(int'($urandom_range(0, 32'h0fffffff)) - 32'h08000000);
        endcase
    endfunction

    function automatic q14_t rand_q14();
        case ($urandom_range(0, 4))
            0:       return q14_t'(ONE14);
            1:       return q14_t'(-ONE14);
            default: return q14_t'(int'($urandom_range(0, 2 * ONE14)) - ONE14);
        endcase
    endfunction

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    task automatic test_directional();
        // reset value first: straight up
        send_point(0, 0, 0);
        wait_idle();
        set_light(KIND_DIR, 32'sh7fffffff, 32'sh80000000, 2);
        send_point(32'sh7fffffff, 32'sh80000000, 0);
        wait_idle();
        // halves round toward plus infinity
        set_light(KIND_DIR, -2, -6, 32'h0000c000);
        send_point(1, 2, 3);
        wait_idle();
    endtask

    task automatic test_point_light();
        set_light(KIND_POINT, 32'h00010000, 32'hfffe0000, 32'h00030000);
        // point on the light: zero direction
        send_point(32'h00010000, 32'hfffe0000, 32'h00030000);
        send_point(0, 0, 0);
        send_point(32'h00010001, 32'hfffe0000, 32'h00030000);
        wait_idle();
        // widest difference
        set_light(KIND_POINT, 32'sh7fffffff, 32'sh7fffffff, 32'sh80000000);
        send_point(32'sh80000000, 32'sh80000000, 32'sh7fffffff);
        send_point(32'sh80000000, 32'sh7fffffff, 32'sh7fffffff);
        wait_idle();
    endtask

    task automatic test_soft_spot();
        set_light(KIND_SOFT, 0, 0, 0);
        set_spot(0, 0, -ONE14, 16'sd8000);
        send_point(0, 0, -65536);               // on axis, full
        send_point(0, 0, 0);                    // zero vector, dot of zero
        send_point(30000, 0, -65536);           // inside, falloff
        send_point(65536, 0, -40000);           // near the edge
        send_point(65536, 0, 65536);            // behind
        wait_idle();
        // cone of zero width
        set_spot(0, 0, -ONE14, 16'sd16384);
        send_point(0, 0, -65536);
        send_point(1000, 0, -65536);
        wait_idle();
        // cone wider than a hemisphere; non-positive dot still dark
        set_spot(0, 0, -ONE14, -16'sd16384);
        send_point(65536, 0, 0);
        send_point(65536, 0, -100);
        wait_idle();
    endtask

    task automatic test_sharp_spot();
        set_light(KIND_SHARP, 32'h00100000, 0, 0);
        set_spot(-ONE14, 0, 0, 16'sd15000);
        send_point(0, 0, 0);                    // on axis
        send_point(0, 32'h00080000, 0);         // outside
        send_point(32'h00100000, 0, 0);         // zero vector
        wait_idle();
        set_spot(-ONE14, 0, 0, -16'sd16384);
        send_point(32'h00200000, 0, 0);         // behind, still lit
        wait_idle();
    endtask

    // Random light set-ups; spot phases mostly aim points into the cone.
    task automatic test_random_lighting();
        coord_t lp[3];
        q14_t ax[3];
        q14_t cone;
        longint scale;
        kind_t kind;
        for (int phase = 0; phase < 13; phase++)
        begin
            no_idling = (phase == 4 || phase == 5);
            kind = kind_t'($urandom_range(0, 3));
            for (int i = 0; i < 3; i++)
            begin
                lp[i] = rand_coord();
                ax[i] = rand_q14();
            end
            case (phase % 4)
                0:       cone = q14_t'(ONE14);
                1:       cone = q14_t'(-ONE14);
                default: cone = q14_t'($urandom_range(0, ONE14));
            endcase
            if (phase >= 9)
                cone = rand_q14();
            set_light(kind, lp[0], lp[1], lp[2]);
            set_spot(ax[0], ax[1], ax[2], cone);
            for (int n = 0; n < 62; n++)
            begin
                if ((kind == KIND_SOFT || kind == KIND_SHARP) && $urandom_range(0, 3) != 0)
                begin
                    scale = longint'($urandom_range(1, 1 << $urandom_range(0, 14)));
                    send_point(coord_t'(longint'(lp[0]) + scale * ax[0]
                                        + int'($urandom_range(0, 2047)) - 1024),
                               coord_t'(longint'(lp[1]) + scale * ax[1]
                                        + int'($urandom_range(0, 2047)) - 1024),
                               coord_t'(longint'(lp[2]) + scale * ax[2]
                                        + int'($urandom_range(0, 2047)) - 1024));
                end
                else
                    send_point(rand_coord(), rand_coord(), rand_coord());
            end
            wait_idle();
        end
        no_idling = 1'b0;
    endtask

    // ---------------------------------------------------------------
    // Sequence
    // ---------------------------------------------------------------

    initial
    begin
        fail_count    = 0;
        no_idling     = 1'b0;
        light_kind    = KIND_DIR;
        light_pos     = '{0, 0, 65536};
        spot_axis     = '{0, 0, 16'sd16384};
        cone_cos      = 0;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        repeat (RESET_CYCLES)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directional();
        test_point_light();
        test_soft_spot();
        test_sharp_spot();
        test_random_lighting();

        wait_idle();
        repeat (SETTLE_CYCLES)
            @(posedge clk);
        if (fail_count == 0 && expected_q.size() == 0)
            $display("light_source_intensity_eval verification clean");
        else
            $display("light_source_intensity_eval verification failed");
        $finish;
    end

    // watchdog
    initial
    begin
        #(2 * HALF_PERIOD * 400000);
        $display("light_source_intensity_eval verification failed");
        $finish;
    end

endmodule
`default_nettype wire
